// ===== sv/abad_pkg.sv =====
package abad_pkg;

    localparam int WORD_W   = 32;
    localparam int TALLY_W  = 14;
    localparam int PERIOD_W = 7;
    localparam int CNT_W    = $clog2(WORD_W + 1);

    localparam logic [WORD_W-1:0]   MIN_LENGTH       = 32'h0100_0000;
    localparam logic [WORD_W-1:0]   MAX_LENGTH       = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]   DIV_DIVIDEND     = 32'h8000_0000;
    localparam logic [PERIOD_W-1:0] PERIOD_CAP       = 7'd64;
    localparam logic [PERIOD_W-1:0] PERIOD_START     = 7'd4;
    localparam logic [TALLY_W-1:0]  ZERO_TALLY_INIT  = 14'd1;
    localparam logic [TALLY_W-1:0]  TOTAL_TALLY_INIT = 14'd2;

    typedef enum logic [1:0] {
        ACT_START       = 2'd0,
        ACT_DECODE      = 2'd1,
        ACT_FEED        = 2'd2,
        ACT_MODEL_RESET = 2'd3
    } action_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SPLIT  = 8'b0000_0010,
        ST_DECIDE = 8'b0000_0100,
        ST_TALLY  = 8'b0000_1000,
        ST_DIV_GO = 8'b0001_0000,
        ST_DIVIDE = 8'b0010_0000,
        ST_SCALE  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic take;
        logic split;
        logic decide;
        logic tally;
        logic div_start;
        logic scale;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic decode_go;
        logic adapt_due;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/abad_div.sv =====
module abad_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [abad_pkg::TALLY_W-1:0]   divisor,
    output logic                           done,
    output logic [abad_pkg::WORD_W-1:0]    quotient
);

    logic [abad_pkg::TALLY_W-1:0] rem_reg;
    logic [abad_pkg::TALLY_W-1:0] dvsr_reg;
    logic [abad_pkg::WORD_W-1:0]  quot_reg;
    logic [abad_pkg::CNT_W-1:0]   cnt_reg;
    logic                         done_reg;

    logic [abad_pkg::TALLY_W:0]   trial;
    logic [abad_pkg::TALLY_W:0]   diff;
    logic                         ge;

    // one restoring step per cycle: bring down the next dividend bit
    always_comb
    begin
        trial = {rem_reg, quot_reg[abad_pkg::WORD_W-1]};
        ge    = trial >= {1'b0, dvsr_reg};
        diff  = trial - {1'b0, dvsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvsr_reg <= divisor;
            quot_reg <= abad_pkg::DIV_DIVIDEND;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[abad_pkg::TALLY_W-1:0] : trial[abad_pkg::TALLY_W-1:0];
            quot_reg <= {quot_reg[abad_pkg::WORD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg <= abad_pkg::CNT_W'(abad_pkg::WORD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            done_reg <= !start && (cnt_reg == abad_pkg::CNT_W'(1));
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== sv/abad_dp.sv =====
module abad_dp #(
    parameter int PROB_SHIFT = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  abad_pkg::ctrl_cmd_t           cmd,
    output abad_pkg::dp_status_t          status,
    input  logic [1:0]                    action,
    input  logic [abad_pkg::WORD_W-1:0]   data,
    output logic                          bit_res,
    output logic                          bit_valid,
    output logic                          need_byte
);

    // zero probability can reach PROB_SHIFT + 14 bits when the tallies wrap
    localparam int ZP_W    = PROB_SHIFT + 15;
    localparam int LHI_W   = abad_pkg::WORD_W - PROB_SHIFT;
    localparam int SPROD_W = ZP_W + LHI_W;
    localparam int QPROD_W = abad_pkg::TALLY_W + abad_pkg::WORD_W;
    localparam int QSHIFT  = abad_pkg::WORD_W - 1 - PROB_SHIFT;
    localparam logic [ZP_W-1:0] ZP_INIT = ZP_W'(1) << (PROB_SHIFT - 1);
    localparam logic [abad_pkg::TALLY_W+1:0] HALVE_AT =
        (abad_pkg::TALLY_W + 2)'(1) << PROB_SHIFT;

    logic [abad_pkg::WORD_W-1:0]   code_reg;
    logic [abad_pkg::WORD_W-1:0]   len_reg;
    logic [ZP_W-1:0]               zp_reg;
    logic [abad_pkg::TALLY_W-1:0]  zero_reg;
    logic [abad_pkg::TALLY_W-1:0]  total_reg;
    logic [abad_pkg::PERIOD_W-1:0] period_reg;
    logic [abad_pkg::PERIOD_W-1:0] togo_reg;
    logic [abad_pkg::WORD_W-1:0]   split_reg;
    logic                          dec_bit_reg;
    logic                          dec_valid_reg;
    logic                          bit_res_reg;
    logic                          bit_valid_reg;
    logic                          need_byte_reg;

    logic                          len_short;
    logic [SPROD_W-1:0]            split_prod;
    logic                          code_ge;
    logic [abad_pkg::TALLY_W-1:0]  tsum;
    logic [abad_pkg::TALLY_W-1:0]  thalf;
    logic [abad_pkg::TALLY_W-1:0]  zhalf;
    logic [abad_pkg::TALLY_W-1:0]  total_next;
    logic [abad_pkg::TALLY_W-1:0]  zero_adapt;
    logic [abad_pkg::PERIOD_W+2:0] p5;
    logic [abad_pkg::PERIOD_W-1:0] period_grow;
    logic [abad_pkg::PERIOD_W-1:0] period_next;
    logic [abad_pkg::TALLY_W-1:0]  divisor;
    logic                          div_done;
    logic [abad_pkg::WORD_W-1:0]   quotient;
    logic [QPROD_W-1:0]            scale_prod;

    abad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        len_short  = len_reg < abad_pkg::MIN_LENGTH;
        split_prod = zp_reg * len_reg[abad_pkg::WORD_W-1:PROB_SHIFT];
        code_ge    = code_reg >= split_reg;

        // periodic model update: grow total and period, halve tallies near limit
        tsum       = total_reg + abad_pkg::TALLY_W'(period_reg);
        thalf      = abad_pkg::TALLY_W'(({1'b0, tsum} + 1'b1) >> 1);
        zhalf      = abad_pkg::TALLY_W'(({1'b0, zero_reg} + 1'b1) >> 1);
        total_next = tsum;
        zero_adapt = zero_reg;
        if ({2'b00, tsum} >= HALVE_AT)
        begin
            zero_adapt = zhalf;
            total_next = (zhalf == thalf) ? thalf + 1'b1 : thalf;
        end

        p5          = {1'b0, period_reg, 2'b00} + (abad_pkg::PERIOD_W + 3)'(period_reg);
        period_grow = abad_pkg::PERIOD_W'(p5 >> 2);
        period_next = (p5[abad_pkg::PERIOD_W+2:2] > (abad_pkg::PERIOD_W + 1)'(abad_pkg::PERIOD_CAP))
                      ? abad_pkg::PERIOD_CAP : period_grow;

        divisor    = (total_reg == '0) ? abad_pkg::TALLY_W'(1) : total_reg;
        scale_prod = zero_reg * quotient;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg      <= '0;
            len_reg       <= '0;
            zp_reg        <= ZP_INIT;
            zero_reg      <= abad_pkg::ZERO_TALLY_INIT;
            total_reg     <= abad_pkg::TOTAL_TALLY_INIT;
            period_reg    <= abad_pkg::PERIOD_START;
            togo_reg      <= abad_pkg::PERIOD_START;
            dec_bit_reg   <= 1'b0;
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                dec_bit_reg   <= 1'b0;
                dec_valid_reg <= 1'b0;
                case (abad_pkg::action_t'(action))
                    abad_pkg::ACT_START:
                    begin
                        code_reg <= data;
                        len_reg  <= abad_pkg::MAX_LENGTH;
                    end
                    abad_pkg::ACT_FEED:
                    begin
                        if (len_short)
                        begin
                            code_reg <= {code_reg[abad_pkg::WORD_W-9:0], data[7:0]};
                            len_reg  <= {len_reg[abad_pkg::WORD_W-9:0], 8'h00};
                        end
                    end
                    abad_pkg::ACT_MODEL_RESET:
                    begin
                        zp_reg     <= ZP_INIT;
                        zero_reg   <= abad_pkg::ZERO_TALLY_INIT;
                        total_reg  <= abad_pkg::TOTAL_TALLY_INIT;
                        period_reg <= abad_pkg::PERIOD_START;
                        togo_reg   <= abad_pkg::PERIOD_START;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.decide)
            begin
                dec_bit_reg   <= code_ge;
                dec_valid_reg <= 1'b1;
                togo_reg      <= togo_reg - 1'b1;
                if (code_ge)
                begin
                    code_reg <= code_reg - split_reg;
                    len_reg  <= len_reg - split_reg;
                end
                else
                begin
                    len_reg  <= split_reg;
                    zero_reg <= zero_reg + 1'b1;
                end
            end

            if (cmd.tally)
            begin
                total_reg  <= total_next;
                zero_reg   <= zero_adapt;
                period_reg <= period_next;
                togo_reg   <= period_next;
            end

            if (cmd.scale)
            begin
                zp_reg <= ZP_W'(scale_prod >> QSHIFT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.split)
        begin
            split_reg <= split_prod[abad_pkg::WORD_W-1:0];
        end
        if (cmd.load_out)
        begin
            bit_res_reg   <= dec_bit_reg;
            bit_valid_reg <= dec_valid_reg;
            need_byte_reg <= len_short;
        end
    end

    assign status.decode_go = (abad_pkg::action_t'(action) == abad_pkg::ACT_DECODE) && !len_short;
    assign status.adapt_due = togo_reg == abad_pkg::PERIOD_W'(1);
    assign status.div_done  = div_done;

    assign bit_res   = bit_res_reg;
    assign bit_valid = bit_valid_reg;
    assign need_byte = need_byte_reg;

endmodule

// ===== sv/abad_ctrl.sv =====
module abad_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  abad_pkg::dp_status_t  status,
    output abad_pkg::ctrl_cmd_t   cmd
);

    abad_pkg::state_t state_reg;
    abad_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_free;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            abad_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = status.decode_go ? abad_pkg::ST_SPLIT : abad_pkg::ST_DONE;
                end
            end
            abad_pkg::ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = abad_pkg::ST_DECIDE;
            end
            abad_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.adapt_due ? abad_pkg::ST_TALLY : abad_pkg::ST_DONE;
            end
            abad_pkg::ST_TALLY:
            begin
                cmd.tally  = 1'b1;
                state_next = abad_pkg::ST_DIV_GO;
            end
            abad_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = abad_pkg::ST_DIVIDE;
            end
            abad_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = abad_pkg::ST_SCALE;
                end
            end
            abad_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = abad_pkg::ST_DONE;
            end
            abad_pkg::ST_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = abad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = abad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = state_reg != abad_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/adaptive_binary_arith_decoder_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  action[1:0], data[31:0]
// out      output     out_valid / out_stall bit_res, bit_valid, need_byte
//
// Start, feed and model reset go IDLE, DONE; a decode with enough length goes
// IDLE, SPLIT, DECIDE, DONE. Every adapt period (4 to 64 decodes) one decode
// also runs TALLY, DIV_GO, the 32-step restoring divider (DIVIDE) and SCALE.
// Reset is asynchronous; the model comes up equiprobable, length zero.
// The output register holds a result while out is stalled; a new transaction
// is taken only when the previous one has moved into that register.
module adaptive_binary_arith_decoder_top #(
    parameter int PROB_SHIFT = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [abad_pkg::WORD_W-1:0]  data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         bit_res,
    output logic                         bit_valid,
    output logic                         need_byte
);

    abad_pkg::ctrl_cmd_t  cmd;
    abad_pkg::dp_status_t status;

    abad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    abad_dp #(
        .PROB_SHIFT (PROB_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .action    (action),
        .data      (data),
        .bit_res   (bit_res),
        .bit_valid (bit_valid),
        .need_byte (need_byte)
    );

endmodule
